@@ hw/rtl/smpq_pkg.sv @@
// Shared types and constants for the sorted minimum priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int unsigned DEPTH_DEF   = 16;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned COUNT_OUT_W = 5;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rm;
    } t_cell_ctl;

endpackage

@@ hw/rtl/smpq_cell.sv @@
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps

module smpq_cell (
    input  logic                                i_clk,
    input  smpq_pkg::t_cell_ctl                 i_ctl,
    input  logic                                i_live,
    input  logic signed [smpq_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_left_gt,
    input  logic signed [smpq_pkg::VALUE_W-1:0] i_left_value,
    input  logic signed [smpq_pkg::VALUE_W-1:0] i_right_value,
    output logic                                o_gt,
    output logic signed [smpq_pkg::VALUE_W-1:0] o_value
);

    logic signed [smpq_pkg::VALUE_W-1:0] r_value;
    logic signed [smpq_pkg::VALUE_W-1:0] n_value;

    // A live entry strictly greater than the new value moves one place right
    assign o_gt    = i_live && (r_value > i_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        priority if (i_ctl.ins) begin
            priority if (i_left_gt) begin
                n_value = i_left_value;
            end else if (i_live && !o_gt) begin
                n_value = r_value;
            end else begin
                n_value = i_value;
            end
        end else if (i_ctl.rm) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ hw/rtl/sorted_min_priority_queue.sv @@
// Top level of the sorted minimum priority queue built as a chain of cells.
`timescale 1ns / 1ps

// Usage:
//   Drive i_op and i_value and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. busy stays low, so a
//   new transaction may be taken in every cycle.
//   Insert (OP_INSERT) places i_value after all stored entries less than or
//   equal to it; remove (OP_REMOVE) takes out the smallest entry.
//   Every transaction gives one result in the cycle after it is taken: o_valid
//   is high for exactly that cycle with o_status, o_removed_value,
//   o_head_value and o_entry_count. The receiver cannot stall the result.
//   Throughput is one transaction per cycle: every cell compares its entry
//   with the new value and shifts left or right in the same cycle, so the
//   work is one compare per cell plus the count update.
//   An insert into a full queue reports full and leaves the queue as it
//   was; a remove from an empty queue reports empty with zero fields.
//   Reset (synchronous, active low) empties the queue and drops any pending
//   result; stored entries keep stale data that is never read.
module sorted_min_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = smpq_pkg::DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [0:0]                              i_op,
    input  logic signed [smpq_pkg::VALUE_W-1:0]     i_value,
    output logic                                    o_valid,
    output logic [1:0]                              o_status,
    output logic signed [smpq_pkg::VALUE_W-1:0]     o_removed_value,
    output logic signed [smpq_pkg::VALUE_W-1:0]     o_head_value,
    output logic [smpq_pkg::COUNT_OUT_W-1:0]        o_entry_count
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EXT_W = (CNT_W > smpq_pkg::COUNT_OUT_W) ?
                                    CNT_W : smpq_pkg::COUNT_OUT_W;

    logic                                   acc;
    logic                                   is_full;
    logic                                   is_empty;
    smpq_pkg::t_op                          op;
    smpq_pkg::t_cell_ctl                    ctl;
    smpq_pkg::t_status                      n_status;
    logic signed [smpq_pkg::VALUE_W-1:0]    n_removed;
    logic signed [smpq_pkg::VALUE_W-1:0]    n_head;
    logic [CNT_W-1:0]                       r_count;
    logic [CNT_W-1:0]                       n_count;
    logic [EXT_W-1:0]                       count_ext;

    logic                                   r_valid;
    smpq_pkg::t_status                      r_status;
    logic signed [smpq_pkg::VALUE_W-1:0]    r_removed;
    logic signed [smpq_pkg::VALUE_W-1:0]    r_head;
    logic [smpq_pkg::COUNT_OUT_W-1:0]       r_entry_count;

    logic [QUEUE_DEPTH-1:0]                 cell_gt;
    logic signed [smpq_pkg::VALUE_W-1:0]    cell_value [QUEUE_DEPTH];

    assign busy     = 1'b0;
    assign acc      = start && !busy;
    assign op       = smpq_pkg::t_op'(i_op);
    assign is_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        ctl.ins   = 1'b0;
        ctl.rm    = 1'b0;
        n_status  = smpq_pkg::ST_OK;
        n_removed = '0;
        n_count   = r_count;
        n_head    = is_empty ? '0 : cell_value[0];
        unique case (op)
            smpq_pkg::OP_INSERT: begin
                if (is_full) begin
                    n_status = smpq_pkg::ST_FULL;
                end else begin
                    ctl.ins = acc;
                    n_count = r_count + CNT_W'(1);
                    n_head  = (is_empty || cell_gt[0]) ? i_value : cell_value[0];
                end
            end
            smpq_pkg::OP_REMOVE: begin
                if (is_empty) begin
                    n_status = smpq_pkg::ST_EMPTY;
                end else begin
                    ctl.rm    = acc;
                    n_removed = cell_value[0];
                    n_count   = r_count - CNT_W'(1);
                    n_head    = (r_count > CNT_W'(1)) ? cell_value[1] : '0;
                end
            end
            default: begin
                n_status = smpq_pkg::ST_OK;
            end
        endcase
    end

    assign count_ext = EXT_W'(n_count);

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                                left_gt;
            logic signed [smpq_pkg::VALUE_W-1:0] left_value;
            logic signed [smpq_pkg::VALUE_W-1:0] right_value;

            if (g == 0) begin : g_first
                assign left_gt    = 1'b0;
                assign left_value = i_value;
            end else begin : g_inner
                assign left_gt    = cell_gt[g-1];
                assign left_value = cell_value[g-1];
            end

            // The last cell holds its own data on remove; it drops out of the live range
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign right_value = cell_value[g];
            end else begin : g_body
                assign right_value = cell_value[g+1];
            end

            smpq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_live        (CNT_W'(g) < r_count),
                .i_value       (i_value),
                .i_left_gt     (left_gt),
                .i_left_value  (left_value),
                .i_right_value (right_value),
                .o_gt          (cell_gt[g]),
                .o_value       (cell_value[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= acc;
            if (acc) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload: captured with each transaction, no reset needed
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status      <= n_status;
            r_removed     <= n_removed;
            r_head        <= n_head;
            r_entry_count <= count_ext[smpq_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_head_value    = r_head;
    assign o_entry_count   = r_entry_count;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_valid)
        else $error("result strobe missing after accepted transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> !o_valid)
        else $error("result strobe without a transaction");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && op == smpq_pkg::OP_INSERT && !is_full) |=>
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not add one entry");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == smpq_pkg::ST_EMPTY) |->
            (o_removed_value == '0 && o_head_value == '0 && r_count == '0))
        else $error("empty remove reported stale data");

endmodule
